/* rtl/core/pcf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types, constants and helper functions for the PNG chunk framer.
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam logic        ACT_BEGIN = 1'b0;
  localparam logic        ACT_DATA  = 1'b1;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;

  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QAW       = $clog2(QDEPTH);
  localparam int unsigned QCW       = $clog2(QDEPTH + 1);

  localparam int unsigned STEP_W    = 4;

  localparam logic [STEP_W-1:0] STEP_TYPE0 = 4'd4;
  localparam logic [STEP_W-1:0] STEP_CRC0  = 4'd8;

  typedef enum logic [2:0] {
    CMD_ERR,
    CMD_DATA,
    CMD_DATA_LAST,
    CMD_BEGIN_OPEN,
    CMD_BEGIN_CLOSE
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [31:0] ctype;
    logic [30:0] clen;
    logic [7:0]  dbyte;
  } cmd_t;

  // one byte of CRC-32, LSB first
  function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // byte of a word, position 0 is the most significant byte
  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] pos);
    logic [7:0] r;
    case (pos)
      2'd0:    r = w[31:24];
      2'd1:    r = w[23:16];
      2'd2:    r = w[15:8];
      default: r = w[7:0];
    endcase
    return r;
  endfunction

  function automatic logic [STEP_W-1:0] last_step(input cmd_e kind);
    logic [STEP_W-1:0] r;
    case (kind)
      CMD_ERR:         r = 4'd0;
      CMD_DATA:        r = 4'd0;
      CMD_DATA_LAST:   r = 4'd4;
      CMD_BEGIN_OPEN:  r = 4'd7;
      CMD_BEGIN_CLOSE: r = 4'd11;
      default:         r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/pcf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_front
// Accepts input beats, tracks the open chunk and classifies each beat.
// ----------------------------------------------------------------------------
module pcf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_action_i,
  input  logic [31:0]   in_ctype_i,
  input  logic [30:0]   in_clen_i,
  input  logic [7:0]    in_dbyte_i,
  input  logic          q_full_i,
  output logic          in_ready_o,
  output logic          push_o,
  output pcf_pkg::cmd_t push_cmd_o
);

  logic        open_q, open_d;
  logic [30:0] remain_q, remain_d;
  logic [30:0] remain_dec;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign remain_dec = remain_q - 31'd1;

  always_comb begin
    open_d           = open_q;
    remain_d         = remain_q;
    push_cmd_o.ctype = in_ctype_i;
    push_cmd_o.clen  = in_clen_i;
    push_cmd_o.dbyte = in_dbyte_i;
    push_cmd_o.kind  = pcf_pkg::CMD_ERR;
    if (in_action_i == pcf_pkg::ACT_BEGIN) begin
      if (!open_q) begin
        if (in_clen_i == 31'd0) begin
          push_cmd_o.kind = pcf_pkg::CMD_BEGIN_CLOSE;
        end else begin
          push_cmd_o.kind = pcf_pkg::CMD_BEGIN_OPEN;
          open_d          = 1'b1;
          remain_d        = in_clen_i;
        end
      end
    end else if (open_q) begin
      remain_d = remain_dec;
      if (remain_dec == 31'd0) begin
        push_cmd_o.kind = pcf_pkg::CMD_DATA_LAST;
        open_d          = 1'b0;
      end else begin
        push_cmd_o.kind = pcf_pkg::CMD_DATA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      remain_q <= '0;
    end else if (push_o) begin
      open_q   <= open_d;
      remain_q <= remain_d;
    end
  end

endmodule

/* rtl/core/pcf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module pcf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pcf_pkg::cmd_t push_cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output pcf_pkg::cmd_t head_o
);

  pcf_pkg::cmd_t               mem_q [pcf_pkg::QDEPTH];
  logic [pcf_pkg::QAW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [pcf_pkg::QCW-1:0]     count_q, count_d;

  assign full_o  = count_q == pcf_pkg::QCW'(pcf_pkg::QDEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

/* rtl/core/pcf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_back
// Steps through the queued command one output beat per cycle while the output is not stalled, runs the
// CRC-32 and holds the output register.
// ----------------------------------------------------------------------------
module pcf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  pcf_pkg::cmd_t         cmd_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  out_last_o,
  output logic                  out_end_o,
  output logic                  out_err_o
);

  logic [pcf_pkg::STEP_W-1:0] step_q, step_d;
  logic [31:0]                crc_q, crc_d;
  logic                       valid_q;
  logic [7:0]                 byte_q, byte_d;
  logic                       last_q, last_d;
  logic                       end_q, end_d;
  logic                       err_q, err_d;
  logic                       adv;
  logic [31:0]                crc_out;
  logic [1:0]                 crc_pos;
  logic [7:0]                 type_byte;

  assign adv       = cmd_valid_i && (!valid_q || out_ready_i);
  assign crc_out   = ~crc_q;
  assign crc_pos   = (cmd_i.kind == pcf_pkg::CMD_DATA_LAST) ? 2'(step_q - 4'd1) : step_q[1:0];
  assign type_byte = pcf_pkg::word_byte(cmd_i.ctype, step_q[1:0]);

  always_comb begin
    byte_d = 8'd0;
    crc_d  = crc_q;
    last_d = step_q == pcf_pkg::last_step(cmd_i.kind);
    end_d  = 1'b0;
    err_d  = 1'b0;
    case (cmd_i.kind)
      pcf_pkg::CMD_ERR: begin
        err_d = 1'b1;
      end
      pcf_pkg::CMD_DATA: begin
        byte_d = cmd_i.dbyte;
        crc_d  = pcf_pkg::crc_fold(crc_q, cmd_i.dbyte);
      end
      pcf_pkg::CMD_DATA_LAST: begin
        end_d = last_d;
        if (step_q == '0) begin
          byte_d = cmd_i.dbyte;
          crc_d  = pcf_pkg::crc_fold(crc_q, cmd_i.dbyte);
        end else begin
          byte_d = pcf_pkg::word_byte(crc_out, crc_pos);
        end
      end
      pcf_pkg::CMD_BEGIN_OPEN, pcf_pkg::CMD_BEGIN_CLOSE: begin
        end_d = last_d && (cmd_i.kind == pcf_pkg::CMD_BEGIN_CLOSE);
        if (step_q < pcf_pkg::STEP_TYPE0) begin
          byte_d = pcf_pkg::word_byte({1'b0, cmd_i.clen}, step_q[1:0]);
        end else if (step_q < pcf_pkg::STEP_CRC0) begin
          byte_d = type_byte;
          crc_d  = pcf_pkg::crc_fold((step_q == pcf_pkg::STEP_TYPE0) ? pcf_pkg::CRC_INIT
                                                                      : crc_q, type_byte);
        end else begin
          byte_d = pcf_pkg::word_byte(crc_out, crc_pos);
        end
      end
      default: begin
        err_d = 1'b1;
      end
    endcase
  end

  assign pop_o  = adv && last_d;
  assign step_d = last_d ? '0 : step_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      crc_q   <= pcf_pkg::CRC_INIT;
      valid_q <= 1'b0;
    end else if (adv) begin
      step_q  <= step_d;
      crc_q   <= crc_d;
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= byte_d;
      last_q <= last_d;
      end_q  <= end_d;
      err_q  <= err_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_end_o   = end_q;
  assign out_err_o   = err_q;

endmodule

/* rtl/core/png_chunk_framer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_chunk_framer
// Frames PNG chunks: length and type header, passed-through data bytes and a
// trailing CRC-32, with an error beat for out-of-sequence input.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                             | tuser              | tlast
//  s_axis   | in  | chunk_type, chunk_length, data_byte | action (0 begin) | -
//  m_axis   | out | out_byte                          | chunk_end, error   | run_last
//
//  A data byte gives one output beat; a begin gives 8 beats (12 with zero length),
//  a closing data byte 5, an error beat 1: the back sequencer emits one beat
//  per cycle while the output is not stalled. Input beats queue up to 4 deep ahead of it.
//  Reset clears the chunk state, the queue, the sequencer step, the CRC and the output valid flag.
//  A stalled output freezes the sequencer; input stalls only when the queue fills.
// ----------------------------------------------------------------------------
module png_chunk_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // chunk_type[31:0], chunk_length[62:32], data_byte[70:63]
  input  logic        s_axis_tuser_i,  // action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // out_byte
  output logic [1:0]  m_axis_tuser_o,  // chunk_end[0], error[1]
  output logic        m_axis_tlast_o   // run_last
);

  logic          q_full;
  logic          q_valid;
  logic          push;
  logic          pop;
  pcf_pkg::cmd_t push_cmd;
  pcf_pkg::cmd_t head_cmd;
  logic          out_end;
  logic          out_err;

  pcf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_action_i(s_axis_tuser_i),
    .in_ctype_i (s_axis_tdata_i[31:0]),
    .in_clen_i  (s_axis_tdata_i[62:32]),
    .in_dbyte_i (s_axis_tdata_i[70:63]),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  pcf_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .full_o    (q_full),
    .valid_o   (q_valid),
    .head_o    (head_cmd)
  );

  pcf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (head_cmd),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_byte_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o),
    .out_end_o  (out_end),
    .out_err_o  (out_err)
  );

  assign m_axis_tuser_o = {out_err, out_end};

endmodule
